// ----- hdl/vtm_pkg.sv -----
package vtm_pkg;

  localparam int MODE_W = 2;
  localparam int SLOT_W = 4;
  localparam int DUR_W  = 16;
  localparam int TPM_W  = 8;
  localparam int PER_W  = 16;
  localparam int KIND_W = 2;
  localparam int SCHED_W = 32;
  // A scaled duration never needs more than the product width.
  localparam int TICK_W = DUR_W + TPM_W;

  localparam logic [TPM_W-1:0] TPM_RESET = 8'd32;

  localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STOP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PERIOD = 2'd2;
  localparam logic [MODE_W-1:0] MODE_EXPIRY = 2'd3;

  localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

  typedef logic [TICK_W-1:0] tick_t;

  // Access bundle for the slot store: one read address, one write per memory.
  typedef struct packed {
    logic [SLOT_W-1:0] rd_addr;
    logic              rem_we;
    logic [SLOT_W-1:0] rem_waddr;
    tick_t             rem_wdata;
    logic              per_we;
    logic [SLOT_W-1:0] per_waddr;
    tick_t             per_wdata;
  } store_req_t;

endpackage

// ----- hdl/vtm_slot_store.sv -----
module vtm_slot_store #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  vtm_pkg::store_req_t req,
  output vtm_pkg::tick_t     rem_q,
  output vtm_pkg::tick_t     per_q
);
  import vtm_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tick_t rem_mem [DEPTH];
  tick_t per_mem [DEPTH];
  tick_t rem_q_r;
  tick_t per_q_r;

  // Remaining counts.
  always_ff @(posedge clk) begin
    if (req.rem_we) begin
      rem_mem[req.rem_waddr[IW-1:0]] <= req.rem_wdata;
    end
    rem_q_r <= rem_mem[req.rd_addr[IW-1:0]];
  end

  // Reload periods.
  always_ff @(posedge clk) begin
    if (req.per_we) begin
      per_mem[req.per_waddr[IW-1:0]] <= req.per_wdata;
    end
    per_q_r <= per_mem[req.rd_addr[IW-1:0]];
  end

  assign rem_q = rem_q_r;
  assign per_q = per_q_r;

endmodule

// ----- hdl/virtual_timer_multiplexer_core.sv -----
// Channel  | Ports                                      | Handshake
// ---------+--------------------------------------------+------------------------------
// input    | in_mode, in_timer_id, in_duration_ms,      | taken when start && !busy
//          | in_periodic, in_new_period                 |
// result   | out_kind .. out_last                       | out_valid, one cycle, no stall
// config   | cfg_wdata (ticks_per_ms)                   | written when cfg_we
//
// Stop and set-period items finish at the edge that takes them; busy stays low.
// A start item registers its scaled duration, then writes the slot while busy;
// its reply appears as busy falls. An expiry walks the slot store one slot per
// cycle, then reports the soonest remaining slot or that the hardware is idle.
// Reset is synchronous and active low; it clears the flags and the scheduler
// state and sets the tick rate to 32. The receiver cannot stall results.
module virtual_timer_multiplexer_core #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [vtm_pkg::MODE_W-1:0] in_mode,
  input  logic [vtm_pkg::SLOT_W-1:0] in_timer_id,
  input  logic [vtm_pkg::DUR_W-1:0]  in_duration_ms,
  input  logic                       in_periodic,
  input  logic [vtm_pkg::PER_W-1:0]  in_new_period,
  output logic                       out_valid,
  output logic [vtm_pkg::KIND_W-1:0] out_kind,
  output logic [vtm_pkg::SLOT_W-1:0] out_slot_id,
  output logic                       out_start_failed,
  output logic                       out_load_hw,
  output logic                       out_restart_hw,
  output logic [vtm_pkg::SCHED_W-1:0] out_schedule_ticks,
  output logic                       out_idle,
  output logic                       out_last,
  input  logic                       cfg_we,
  input  logic [vtm_pkg::TPM_W-1:0]  cfg_wdata
);
  import vtm_pkg::*;

  // Slot identifiers are four bits wide, so at most sixteen slots are usable.
  localparam int USABLE = (NUM_SLOTS > 16) ? 16 : NUM_SLOTS;
  localparam int IW     = (USABLE > 1) ? $clog2(USABLE) : 1;
  localparam int CW     = $clog2(USABLE + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_EXP   = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [TPM_W-1:0] tpm_r, tpm_nxt;
  logic [USABLE-1:0] active_r, active_nxt;
  logic [USABLE-1:0] reload_r, reload_nxt;
  logic hw_run_r, hw_run_nxt;
  tick_t ct_r, ct_nxt;

  // Start bookkeeping captured when the item is taken.
  tick_t ticks_r, ticks_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic per_r, per_nxt;
  logic full_r, full_nxt;

  // Expiry walk: read index, the slot whose data is on the read port, and the
  // running minimum over slots that stay active.
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [SLOT_W-1:0] pidx_r, pidx_nxt;
  logic pv_r, pv_nxt;
  logic found_r, found_nxt;
  tick_t best_r, best_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic out_fail_r, out_fail_nxt;
  logic out_load_r, out_load_nxt;
  logic out_restart_r, out_restart_nxt;
  tick_t out_sched_r, out_sched_nxt;
  logic out_idle_r, out_idle_nxt;
  logic out_last_r, out_last_nxt;

  store_req_t req;
  tick_t rem_q;
  tick_t per_q;

  logic accept;
  logic id_ok;
  logic free_found;
  logic [SLOT_W-1:0] free_idx;
  logic load;
  logic p_act;
  logic p_rel;
  logic p_exp;
  logic p_keep;
  tick_t p_new;

  vtm_slot_store #(
    .DEPTH (USABLE)
  ) u_store (
    .clk   (clk),
    .req   (req),
    .rem_q (rem_q),
    .per_q (per_q)
  );

  assign accept = start && !busy;
  assign id_ok  = ({1'b0, in_timer_id} < 5'(USABLE));

  // Lowest free slot among the usable ones.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = USABLE - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // A new count reprograms the hardware when it is idle or the count is sooner.
  assign load = !hw_run_r || (ticks_r < ct_r);

  // The slot on the read port: it expires when the elapsed timeout covers it.
  assign p_act  = active_r[pidx_r[IW-1:0]];
  assign p_rel  = reload_r[pidx_r[IW-1:0]];
  assign p_exp  = p_act && (ct_r >= rem_q);
  assign p_keep = p_act && (!p_exp || p_rel);
  assign p_new  = p_exp ? per_q : (rem_q - ct_r);

  always_comb begin
    state_nxt  = state_r;
    tpm_nxt    = tpm_r;
    active_nxt = active_r;
    reload_nxt = reload_r;
    hw_run_nxt = hw_run_r;
    ct_nxt     = ct_r;
    ticks_nxt  = ticks_r;
    slot_nxt   = slot_r;
    per_nxt    = per_r;
    full_nxt   = full_r;
    rd_idx_nxt = rd_idx_r;
    pidx_nxt   = pidx_r;
    pv_nxt     = 1'b0;
    found_nxt  = found_r;
    best_nxt   = best_r;

    out_valid_nxt   = 1'b0;
    out_kind_nxt    = out_kind_r;
    out_slot_nxt    = out_slot_r;
    out_fail_nxt    = out_fail_r;
    out_load_nxt    = out_load_r;
    out_restart_nxt = out_restart_r;
    out_sched_nxt   = out_sched_r;
    out_idle_nxt    = out_idle_r;
    out_last_nxt    = out_last_r;

    req           = '0;
    req.rd_addr   = SLOT_W'(rd_idx_r);
    req.rem_waddr = slot_r;
    req.per_waddr = slot_r;
    req.rem_wdata = ticks_r;
    req.per_wdata = ticks_r;

    if (cfg_we) begin
      tpm_nxt = cfg_wdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_START: begin
              // The scaled count is registered before it is compared or stored.
              ticks_nxt = TICK_W'(in_duration_ms) * TICK_W'(tpm_r);
              slot_nxt  = free_idx;
              per_nxt   = in_periodic;
              full_nxt  = !free_found;
              state_nxt = ST_START;
            end
            MODE_STOP: begin
              if (id_ok) begin
                active_nxt[in_timer_id[IW-1:0]] = 1'b0;
              end
            end
            MODE_PERIOD: begin
              req.per_we    = id_ok;
              req.per_waddr = in_timer_id;
              req.per_wdata = TICK_W'(in_new_period);
            end
            default: begin
              rd_idx_nxt = '0;
              found_nxt  = 1'b0;
              best_nxt   = '0;
              state_nxt  = ST_EXP;
            end
          endcase
        end
      end

      ST_START: begin
        out_valid_nxt   = 1'b1;
        out_kind_nxt    = KIND_START;
        out_last_nxt    = 1'b1;
        if (full_r) begin
          out_slot_nxt    = '0;
          out_fail_nxt    = 1'b1;
          out_load_nxt    = 1'b0;
          out_restart_nxt = 1'b0;
          out_sched_nxt   = '0;
          out_idle_nxt    = !hw_run_r;
        end else begin
          req.rem_we = 1'b1;
          req.per_we = 1'b1;
          active_nxt[slot_r[IW-1:0]] = 1'b1;
          reload_nxt[slot_r[IW-1:0]] = per_r;
          hw_run_nxt = 1'b1;
          if (load) begin
            ct_nxt = ticks_r;
          end
          out_slot_nxt    = slot_r;
          out_fail_nxt    = 1'b0;
          out_load_nxt    = load;
          out_restart_nxt = !hw_run_r;
          out_sched_nxt   = load ? ticks_r : '0;
          out_idle_nxt    = 1'b0;
        end
        state_nxt = ST_IDLE;
      end

      ST_EXP: begin
        // Issue the next read while the previous slot is being updated.
        if (rd_idx_r < CW'(USABLE)) begin
          pidx_nxt   = SLOT_W'(rd_idx_r);
          pv_nxt     = 1'b1;
          rd_idx_nxt = CW'(rd_idx_r + 1'b1);
        end

        if (pv_r) begin
          req.rem_we    = p_keep;
          req.rem_waddr = pidx_r;
          req.rem_wdata = p_new;
          if (p_exp && !p_rel) begin
            active_nxt[pidx_r[IW-1:0]] = 1'b0;
          end
          if (p_keep && (!found_r || (p_new < best_r))) begin
            found_nxt = 1'b1;
            best_nxt  = p_new;
          end
          if (p_exp) begin
            out_valid_nxt   = 1'b1;
            out_kind_nxt    = KIND_EXPIRE;
            out_slot_nxt    = pidx_r;
            out_fail_nxt    = 1'b0;
            out_load_nxt    = 1'b0;
            out_restart_nxt = 1'b0;
            out_sched_nxt   = '0;
            out_idle_nxt    = 1'b0;
            out_last_nxt    = 1'b0;
          end
        end else if (rd_idx_r == CW'(USABLE)) begin
          // Walk finished: schedule the soonest remaining slot or go idle.
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_DONE;
          out_slot_nxt    = '0;
          out_fail_nxt    = 1'b0;
          out_restart_nxt = 1'b0;
          out_last_nxt    = 1'b1;
          out_load_nxt    = found_r;
          out_sched_nxt   = found_r ? best_r : '0;
          out_idle_nxt    = !found_r;
          if (found_r) begin
            ct_nxt = best_r;
          end else begin
            hw_run_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tpm_r       <= TPM_RESET;
      active_r    <= '0;
      reload_r    <= '0;
      hw_run_r    <= 1'b0;
      ct_r        <= '0;
      rd_idx_r    <= '0;
      pv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tpm_r       <= tpm_nxt;
      active_r    <= active_nxt;
      reload_r    <= reload_nxt;
      hw_run_r    <= hw_run_nxt;
      ct_r        <= ct_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pv_r        <= pv_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    ticks_r       <= ticks_nxt;
    slot_r        <= slot_nxt;
    per_r         <= per_nxt;
    full_r        <= full_nxt;
    pidx_r        <= pidx_nxt;
    best_r        <= best_nxt;
    out_kind_r    <= out_kind_nxt;
    out_slot_r    <= out_slot_nxt;
    out_fail_r    <= out_fail_nxt;
    out_load_r    <= out_load_nxt;
    out_restart_r <= out_restart_nxt;
    out_sched_r   <= out_sched_nxt;
    out_idle_r    <= out_idle_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_slot_id        = out_slot_r;
  assign out_start_failed   = out_fail_r;
  assign out_load_hw        = out_load_r;
  assign out_restart_hw     = out_restart_r;
  assign out_schedule_ticks = SCHED_W'(out_sched_r);
  assign out_idle           = out_idle_r;
  assign out_last           = out_last_r;

  // The closing item of an event shows only once the block is free again.
  a_last_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("final result shown while busy");

  // Expired-slot items come only from an expiry walk still in progress.
  a_mid_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy && (out_kind == KIND_EXPIRE))
    else $error("expired slot reported outside an expiry walk");

  // Whatever is programmed into the hardware is the tracked timeout.
  a_load_matches : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_load_hw |-> out_schedule_ticks == SCHED_W'(ct_r) && hw_run_r)
    else $error("programmed count differs from tracked timeout");

  // A counter restart always comes with a load.
  a_restart_load : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_restart_hw |-> out_load_hw)
    else $error("restart without load");

endmodule
